// File: src/cbs_pkg.sv
// Package for the checksummed bank store: sizes, codes, the entry layout and
// the check byte functions. No dependencies; all other files but cbs_ram import it.
package cbs_pkg;

  // Store geometry.
  localparam int NUM_BANKS  = 8;
  localparam int DATA_BYTES = 8;
  localparam int WORD_BYTES = 8;
  localparam int BANK_W     = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int CNT_W      = $clog2(NUM_BANKS + 1);
  localparam int ENTRY_W    = 8 * WORD_BYTES + 16;

  // Reset value of the read-only bank limit.
  localparam logic [3:0] RO_BANKS_RST = 4'd1;

  typedef enum logic [2:0] {
    ACT_RD_BANK = 3'd0,
    ACT_WR_BANK = 3'd1,
    ACT_ERASE   = 3'd2,
    ACT_RD_BYTE = 3'd3,
    ACT_WR_BYTE = 3'd4,
    ACT_SCAN    = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_READ_ONLY = 2'd2,
    ST_BAD_SUM   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_SCAN
  } fsm_t;

  // One memory word: check pair (complement over sum) above the data bytes.
  typedef struct packed {
    logic [15:0]             pair;
    logic [8*WORD_BYTES-1:0] data;
  } entry_t;

  // Requests from the controller to the bank memory.
  typedef struct packed {
    logic              we;
    logic [BANK_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [BANK_W-1:0] raddr;
  } mem_req_t;

  // An accepted input item held for the duration of its work.
  typedef struct packed {
    logic [2:0]              action;
    logic [7:0]              bank_num;
    logic [7:0]              byte_num;
    logic [8*WORD_BYTES-1:0] wr_data;
    logic [7:0]              byte_value;
  } item_t;

  // Modulo-256 sum of the data bytes.
  function automatic logic [7:0] byte_sum(input logic [8*WORD_BYTES-1:0] data);
    logic [7:0] s;
    s = '0;
    for (int i = 0; i < DATA_BYTES; i++) begin
      s = s + data[8*i +: 8];
    end
    return s;
  endfunction

  // A bank is good when both check bytes agree with its data.
  function automatic logic entry_good(input entry_t e);
    logic [7:0] s;
    s = byte_sum(e.data);
    return (e.pair == {~s, s});
  endfunction

  // Builds a stored word: bytes beyond the data width dropped, fresh pair.
  function automatic entry_t make_entry(input logic [8*WORD_BYTES-1:0] data);
    logic [8*WORD_BYTES-1:0] d;
    logic [7:0]              s;
    d = data;
    for (int i = 0; i < WORD_BYTES; i++) begin
      if (i >= DATA_BYTES) begin
        d[8*i +: 8] = '0;
      end
    end
    s = byte_sum(d);
    return '{pair: {~s, s}, data: d};
  endfunction

endpackage

// File: src/cbs_ifs.sv
// Valid/ready channel interfaces for the input items and the result items.
// Depends on cbs_pkg for the word width.
interface cbs_in_if;
  import cbs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [2:0]              action;
  logic [7:0]              bank_num;
  logic [7:0]              byte_num;
  logic [8*WORD_BYTES-1:0] wr_data;
  logic [7:0]              byte_value;

  modport source (output valid, action, bank_num, byte_num, wr_data, byte_value,
                  input ready);
  modport sink (input valid, action, bank_num, byte_num, wr_data, byte_value,
                output ready);
endinterface

interface cbs_out_if;
  import cbs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic [8*WORD_BYTES-1:0] read_data;
  logic [7:0]              byte_data;
  logic [7:0]              bad_bank_mask;

  modport source (output valid, status, read_data, byte_data, bad_bank_mask,
                  input ready);
  modport sink (input valid, status, read_data, byte_data, bad_bank_mask,
                output ready);
endinterface

// File: src/cbs_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module cbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/cbs_core.sv
// Controller of the bank store: item sequencing, check byte verification,
// read-modify-write of the bank memory, the scan and the result register.
// Depends on cbs_pkg and the channel interfaces in cbs_ifs.
module cbs_core
  import cbs_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic [3:0]      ro_banks,
  cbs_in_if.sink          in_ch,
  cbs_out_if.source       out_ch,
  output mem_req_t        mem_req,
  input  entry_t          mem_rdata
);

  fsm_t                    state_r, state_nxt;
  item_t                   item_r;
  logic [NUM_BANKS-1:0]    vld_r, vld_nxt;
  logic                    rd_vld_r, rd_vld_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    iss_r, iss_nxt;
  logic [BANK_W-1:0]       chk_idx_r, chk_idx_nxt;
  logic [7:0]              mask_r, mask_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              status_r, status_nxt;
  logic [8*WORD_BYTES-1:0] rdata_r, rdata_nxt;
  logic [7:0]              bdata_r, bdata_nxt;
  logic [7:0]              obmask_r, obmask_nxt;
  logic                    load_out;

  logic                    accept;
  logic                    out_free;
  entry_t                  ent;
  logic                    good;
  logic                    bank_ok;
  logic                    byte_ok;
  logic                    ro_hit;
  logic [BANK_W-1:0]       bank_sel;
  logic [7:0]              byte_sel;
  logic [8*WORD_BYTES-1:0] byte_ins;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Entries never written since reset read as all zeros.
  assign ent  = rd_vld_r ? mem_rdata : '0;
  assign good = entry_good(ent);

  // Argument checks on the held item.
  assign bank_ok  = (item_r.bank_num < 8'(NUM_BANKS));
  assign byte_ok  = (item_r.byte_num < 8'(DATA_BYTES));
  assign ro_hit   = (item_r.bank_num < {4'd0, ro_banks});
  assign bank_sel = item_r.bank_num[BANK_W-1:0];

  // Byte extract and byte insert on the bank just read.
  always_comb begin
    byte_sel = '0;
    byte_ins = ent.data;
    for (int i = 0; i < WORD_BYTES; i++) begin
      if (item_r.byte_num[2:0] == 3'(i)) begin
        byte_sel            = ent.data[8*i +: 8];
        byte_ins[8*i +: 8]  = item_r.byte_value;
      end
    end
  end

  // State register and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
      cnt_r       <= '0;
      iss_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      rd_vld_r    <= rd_vld_nxt;
      cnt_r       <= cnt_nxt;
      iss_r       <= iss_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Held item, scan mask and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.action     <= in_ch.action;
      item_r.bank_num   <= in_ch.bank_num;
      item_r.byte_num   <= in_ch.byte_num;
      item_r.wr_data    <= in_ch.wr_data;
      item_r.byte_value <= in_ch.byte_value;
    end
    chk_idx_r <= chk_idx_nxt;
    mask_r    <= mask_nxt;
    if (load_out) begin
      status_r <= status_nxt;
      rdata_r  <= rdata_nxt;
      bdata_r  <= bdata_nxt;
      obmask_r <= obmask_nxt;
    end
  end

  // Next state, memory requests and results.
  always_comb begin
    state_nxt   = state_r;
    vld_nxt     = vld_r;
    rd_vld_nxt  = rd_vld_r;
    cnt_nxt     = cnt_r;
    iss_nxt     = 1'b0;
    chk_idx_nxt = chk_idx_r;
    mask_nxt    = mask_r;
    load_out    = 1'b0;
    status_nxt  = ST_OK;
    rdata_nxt   = '0;
    bdata_nxt   = '0;
    obmask_nxt  = '0;
    mem_req     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          mask_nxt = '0;
          cnt_nxt  = '0;
          if (in_ch.action == ACT_SCAN) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_READ;
          end
        end
      end

      S_READ: begin
        if (bank_ok) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = bank_sel;
          rd_vld_nxt    = vld_r[bank_sel];
        end
        state_nxt = S_EXEC;
      end

      S_EXEC: begin
        // Decide the result and any write-back of the bank.
        case (item_r.action)
          ACT_RD_BANK: begin
            if (!bank_ok) begin
              status_nxt = ST_INVALID;
            end else begin
              rdata_nxt = ent.data;
              if (!good) begin
                status_nxt = ST_BAD_SUM;
              end
            end
          end
          ACT_WR_BANK: begin
            if (ro_hit) begin
              status_nxt = ST_READ_ONLY;
            end else if (!bank_ok) begin
              status_nxt = ST_INVALID;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.wdata = make_entry(item_r.wr_data);
            end
          end
          ACT_ERASE: begin
            if (!bank_ok) begin
              status_nxt = ST_INVALID;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.wdata = make_entry('0);
            end
          end
          ACT_RD_BYTE: begin
            if (!byte_ok || !bank_ok) begin
              status_nxt = ST_INVALID;
            end else if (!good) begin
              status_nxt = ST_BAD_SUM;
            end else begin
              bdata_nxt = byte_sel;
            end
          end
          ACT_WR_BYTE: begin
            if (!byte_ok || !bank_ok) begin
              status_nxt = ST_INVALID;
            end else if (!good) begin
              status_nxt = ST_BAD_SUM;
            end else if (ro_hit) begin
              status_nxt = ST_READ_ONLY;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.wdata = make_entry(byte_ins);
            end
          end
          default: begin
            status_nxt = ST_INVALID;
          end
        endcase
        mem_req.waddr = bank_sel;
        // Hold everything until the result register is free.
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
          if (mem_req.we) begin
            vld_nxt[bank_sel] = 1'b1;
          end
        end else begin
          mem_req.we = 1'b0;
        end
      end

      S_SCAN: begin
        // Issue one bank read a cycle and check the one read the cycle before.
        if (cnt_r < CNT_W'(NUM_BANKS)) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = cnt_r[BANK_W-1:0];
          rd_vld_nxt    = vld_r[cnt_r[BANK_W-1:0]];
          iss_nxt       = 1'b1;
          chk_idx_nxt   = cnt_r[BANK_W-1:0];
          cnt_nxt       = cnt_r + CNT_W'(1);
        end
        if (iss_r) begin
          if (!good) begin
            mask_nxt[chk_idx_r] = 1'b1;
          end
        end else if (cnt_r == CNT_W'(NUM_BANKS)) begin
          obmask_nxt = mask_r;
          if (out_free) begin
            load_out  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = load_out || (out_valid_r && !out_ch.ready);
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.read_data     = rdata_r;
  assign out_ch.byte_data     = bdata_r;
  assign out_ch.bad_bank_mask = obmask_r;

  // The memory is never written and read in the same cycle.
  assert property (@(posedge clk) disable iff (!rst_n) !(mem_req.we && mem_req.re))
    else $error("bank memory written and read in the same cycle");

  // Writes happen only while an item is being evaluated.
  assert property (@(posedge clk) disable iff (!rst_n) mem_req.we |-> state_r == S_EXEC)
    else $error("bank memory written outside evaluation");

  // A written bank is marked valid from the next cycle on.
  assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |=> vld_r[$past(mem_req.waddr)])
    else $error("written bank not marked valid");

  // The scan counter never runs past the bank count.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> cnt_r <= CNT_W'(NUM_BANKS))
    else $error("scan counter overran the bank count");

  // A result is loaded only when the result register can take it.
  assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten before it was taken");

endmodule

// File: src/checksummed_bank_store_unit.sv
// Top level of the checksummed bank store: read-only limit register, bank
// memory and controller. Depends on cbs_pkg, cbs_ifs, cbs_ram and cbs_core.
//
// The store holds NUM_BANKS banks of eight data bytes, each with a byte sum
// and its complement, in one memory with a registered read. Every item gives
// exactly one result item. Bank and byte actions pass from the accepting
// cycle through the memory read to the evaluation with write-back, which
// loads the result. A scan reads one bank a cycle. A new item is taken once
// the previous one is evaluated, while its result may still wait in the
// output register; a held result stalls only the evaluation of the next item
// or the end of a scan. Never written banks read as zeros, so they fail their
// check until written or erased. The read-only limit resets to one and is
// written through cfg_we and cfg_data; the user must write it only while the
// block is idle, which the block itself does not enforce.
module checksummed_bank_store_unit
  import cbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  cbs_in_if.sink     in_ch,
  cbs_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data
);

  logic [3:0] ro_banks_r;
  mem_req_t   mem_req;
  entry_t     mem_rdata;

  // Read-only bank limit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ro_banks_r <= RO_BANKS_RST;
    end else if (cfg_we) begin
      ro_banks_r <= cfg_data;
    end
  end

  // Bank memory: data bytes and check pair in one word.
  cbs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_BANKS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // Controller and result register.
  cbs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .ro_banks  (ro_banks_r),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

endmodule
